@@ design/third_order_state_space_plant_assert.svh @@
// Assertion macros for the state-space plant.
`ifndef THIRD_ORDER_STATE_SPACE_PLANT_ASSERT_SVH
`define THIRD_ORDER_STATE_SPACE_PLANT_ASSERT_SVH

`define TOSSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define TOSSP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/tossp_pkg.sv @@
`default_nettype none
package tossp_pkg;

  localparam int GAIN_W = 18;
  localparam int TAB_N  = 32;

  localparam logic [2:0] CFG_RATE   = 3'd0;
  localparam logic [2:0] CFG_GAIN_0 = 3'd1;
  localparam logic [2:0] CFG_GAIN_1 = 3'd2;
  localparam logic [2:0] CFG_GAIN_2 = 3'd3;

  // A and B in units of 1e-4: entry rate*12 + row*4 + col, col 3 is B
  localparam int RAW_TAB [TAB_N] = '{
    9998, 995, 47, 1051,
    -47, 9858, 902, 1040,
    -902, -2752, 8055, 713,
    10000, 100, 0, 101,
    0, 9999, 99, 100,
    -99, -298, 9801, 97,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic clr;
    logic load;
    logic step;
    logic msb;
  } mac_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOAD  = 4'b0010,
    ST_MUL   = 4'b0100,
    ST_ROUND = 4'b1000
  } seq_state_t;

endpackage
`default_nettype wire

@@ design/tossp_mac.sv @@
`default_nettype none
module tossp_mac #(
  parameter int SW = 32,
  parameter int CW = 18,
  parameter int F  = 16
) (
  input  wire logic                 clk,
  input  wire tossp_pkg::mac_ctrl_t ctrl,
  input  wire logic signed [CW-1:0] coef,
  input  wire logic signed [SW-1:0] x,
  output logic signed [SW-1:0]      res
);

  localparam int AW = SW + CW + 2;

  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [AW-1:0] mc_r, mc_nxt;
  logic        [CW-1:0] cf_r, cf_nxt;
  logic signed [AW-1:0] addend;
  logic signed [AW-1:0] rnd;
  logic signed [AW-1:0] sh;

  always_comb begin
    addend = '0;
    if (cf_r[0]) begin
      addend = ctrl.msb ? -mc_r : mc_r;
    end
    acc_nxt = acc_r;
    mc_nxt  = mc_r;
    cf_nxt  = cf_r;
    if (ctrl.clr) begin
      acc_nxt = '0;
    end else if (ctrl.step) begin
      acc_nxt = acc_r + addend;
    end
    if (ctrl.load) begin
      mc_nxt = {{(AW-SW){x[SW-1]}}, x};
      cf_nxt = coef;
    end else if (ctrl.step) begin
      mc_nxt = mc_r <<< 1;
      cf_nxt = cf_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    cf_r  <= cf_nxt;
  end

  always_comb begin
    rnd = acc_r + (AW'(1) <<< (F - 1));
    sh  = rnd >>> F;
    if ((&sh[AW-1:SW-1]) || !(|sh[AW-1:SW-1])) begin
      res = sh[SW-1:0];
    end else if (sh[AW-1]) begin
      res = {1'b1, {(SW-1){1'b0}}};
    end else begin
      res = {1'b0, {(SW-1){1'b1}}};
    end
  end

endmodule
`default_nettype wire

@@ design/third_order_state_space_plant.sv @@
// Third-order state-space plant, bit-serial fixed point.
// Input channel (in_valid/in_ready) takes one drive sample u per beat.
// Result channel (out_valid/out_ready) gives one plant output y per beat.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready: index 0 selects the 10 Hz or 100 Hz table, 1..2..3 set the output
// gains; other indexes are ignored. Write it only while the block is idle.
// Each sample runs 15 coefficient products through one shift-add unit,
// one coefficient bit per cycle; the coefficient width CW is
// max(18, COEF_FRAC_BITS+2). in_ready is high only while no sample is in
// work; one sample at a time.
// The output register holds y until taken; the next sample may be accepted
// meanwhile, and the block holds its final step while the register is full.
// Synchronous reset clears the state to zero, selects the 10 Hz table, sets
// gains to 1.0, 0, 0 and empties the output register.
`default_nettype none
module third_order_state_space_plant #(
  parameter int SAMPLE_WIDTH   = 32,
  parameter int COEF_FRAC_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_drive_sample,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      out_plant_output,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [2:0]                     cfg_index,
  input  wire logic [tossp_pkg::GAIN_W-1:0]   cfg_data
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int GW = tossp_pkg::GAIN_W;
  localparam int CW = (COEF_FRAC_BITS + 2 > GW) ? COEF_FRAC_BITS + 2 : GW;
  localparam int BW = $clog2(CW);

  typedef logic signed [CW-1:0] coef_tab_t [tossp_pkg::TAB_N];

  function automatic coef_tab_t build_tab();
    coef_tab_t t;
    longint    s;
    for (int i = 0; i < tossp_pkg::TAB_N; i++) begin
      s = longint'(tossp_pkg::RAW_TAB[i]) * (longint'(1) << COEF_FRAC_BITS);
      if (s >= 0) begin
        t[i] = CW'((s + 5000) / 10000);
      end else begin
        t[i] = CW'(-((-s + 5000) / 10000));
      end
    end
    return t;
  endfunction

  localparam coef_tab_t COEF_TAB = build_tab();

  tossp_pkg::seq_state_t state_r, state_nxt;
  logic [1:0]           row_r, row_nxt;
  logic [1:0]           col_r, col_nxt;
  logic [BW-1:0]        bit_r, bit_nxt;
  logic                 rate_r;
  logic signed [GW-1:0] gain_r [3];
  logic signed [SW-1:0] x_r [3];
  logic signed [SW-1:0] nw_r [3];
  logic signed [SW-1:0] u_r;
  logic signed [SW-1:0] y_r;
  logic                 out_valid_r;
  logic [4:0]           tab_idx;
  logic signed [CW-1:0] coef_sel;
  logic signed [SW-1:0] x_sel;
  logic signed [SW-1:0] mac_res;
  logic                 last_col;
  logic                 slot_free;
  tossp_pkg::mac_ctrl_t ctrl;

  assign in_ready         = (state_r == tossp_pkg::ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_plant_output = y_r;
  assign slot_free        = !out_valid_r || out_ready;
  assign last_col         = (row_r == 2'd3) ? (col_r == 2'd2) : (col_r == 2'd3);

  always_comb begin
    tab_idx = (rate_r ? 5'd12 : 5'd0) + {1'b0, row_r, col_r};
    if (row_r == 2'd3) begin
      coef_sel = CW'(gain_r[col_r]);
      x_sel    = x_r[col_r];
    end else begin
      coef_sel = COEF_TAB[tab_idx];
      x_sel    = (col_r == 2'd3) ? u_r : x_r[col_r];
    end
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    bit_nxt   = bit_r;
    ctrl      = '0;
    case (state_r)
      tossp_pkg::ST_IDLE: begin
        if (in_valid) begin
          ctrl.clr  = 1'b1;
          row_nxt   = 2'd0;
          col_nxt   = 2'd0;
          state_nxt = tossp_pkg::ST_LOAD;
        end
      end
      tossp_pkg::ST_LOAD: begin
        ctrl.load = 1'b1;
        bit_nxt   = '0;
        state_nxt = tossp_pkg::ST_MUL;
      end
      tossp_pkg::ST_MUL: begin
        ctrl.step = 1'b1;
        ctrl.msb  = (bit_r == BW'(CW - 1));
        bit_nxt   = bit_r + 1'b1;
        if (ctrl.msb) begin
          if (last_col) begin
            state_nxt = tossp_pkg::ST_ROUND;
          end else begin
            col_nxt   = col_r + 1'b1;
            state_nxt = tossp_pkg::ST_LOAD;
          end
        end
      end
      tossp_pkg::ST_ROUND: begin
        if (row_r != 2'd3) begin
          ctrl.clr  = 1'b1;
          row_nxt   = row_r + 1'b1;
          col_nxt   = 2'd0;
          state_nxt = tossp_pkg::ST_LOAD;
        end else if (slot_free) begin
          state_nxt = tossp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tossp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tossp_pkg::ST_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
      rate_r      <= 1'b0;
      gain_r[0]   <= GW'(65536);
      gain_r[1]   <= '0;
      gain_r[2]   <= '0;
      x_r[0]      <= '0;
      x_r[1]      <= '0;
      x_r[2]      <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      bit_r   <= bit_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          tossp_pkg::CFG_RATE:   rate_r    <= cfg_data[0];
          tossp_pkg::CFG_GAIN_0: gain_r[0] <= cfg_data;
          tossp_pkg::CFG_GAIN_1: gain_r[1] <= cfg_data;
          tossp_pkg::CFG_GAIN_2: gain_r[2] <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state_r == tossp_pkg::ST_ROUND && row_r == 2'd2) begin
        x_r[0] <= nw_r[0];
        x_r[1] <= nw_r[1];
        x_r[2] <= mac_res;
      end
      if (state_r == tossp_pkg::ST_ROUND && row_r == 2'd3 && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      u_r <= in_drive_sample;
    end
    if (state_r == tossp_pkg::ST_ROUND && row_r != 2'd3) begin
      nw_r[row_r] <= mac_res;
    end
    if (state_r == tossp_pkg::ST_ROUND && row_r == 2'd3 && slot_free) begin
      y_r <= mac_res;
    end
  end

  tossp_mac #(
    .SW (SW),
    .CW (CW),
    .F  (COEF_FRAC_BITS)
  ) u_mac (
    .clk  (clk),
    .ctrl (ctrl),
    .coef (coef_sel),
    .x    (x_sel),
    .res  (mac_res)
  );

endmodule
`default_nettype wire

@@ design/tossp_checker.sv @@
`default_nettype none
`include "third_order_state_space_plant_assert.svh"
module tossp_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] out_plant_output
);

  `TOSSP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped")
  `TOSSP_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_plant_output), "result changed")
  `TOSSP_ASSERT(a_busy, in_valid && in_ready |=> !in_ready, "second beat taken while busy")
  `TOSSP_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result after reset")

endmodule

bind third_order_state_space_plant tossp_checker u_tossp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_plant_output (out_plant_output[31:0])
);
`default_nettype wire
